// ----- sv/tsps_pkg.sv -----
// constants, types and register map for the timed search pattern sequencer
// no dependencies; used by timed_search_pattern_sequencer_top and the testbench
package tsps_pkg;

    // timing base and limits
    localparam int TICKS_PER_SECOND = 20;
    localparam int ELAPSED_W        = 16;
    localparam int CYCLE_W          = 8;
    localparam int SPEED_W          = 11;
    localparam int RATE_W           = 12;
    localparam int PHASE_W          = 3;
    localparam int TPS_W            = $clog2(TICKS_PER_SECOND + 1);
    localparam int PROD_W           = CYCLE_W + TPS_W;
    localparam int SUM_W            = ((PROD_W > ELAPSED_W) ? PROD_W : ELAPSED_W) + 1;

    localparam logic [SPEED_W-1:0]   SPEED_MAX   = 11'd2000;
    localparam logic [SPEED_W-1:0]   RATE_MAX    = 11'd1500;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 16'hFFFF;
    localparam logic [CYCLE_W-1:0]   CYCLE_MAX   = 8'hFF;

    // register reset values
    localparam logic [15:0]        FORWARD_TICKS_RST = 16'd80;
    localparam logic [15:0]        SPIN_TICKS_RST    = 16'd130;
    localparam logic [15:0]        SHORT_TURN_RST    = 16'd70;
    localparam logic [15:0]        LONG_TURN_RST     = 16'd140;
    localparam logic [SPEED_W-1:0] DRIVE_SPEED_RST   = 11'd650;
    localparam logic [SPEED_W-1:0] TURN_RATE_RST     = 11'd1000;

    // register indexes
    localparam int                 ADDR_W            = 5;
    localparam logic [2:0]         REG_SPIN_FIRST    = 3'd0;
    localparam logic [2:0]         REG_SKEW          = 3'd1;
    localparam logic [2:0]         REG_FORWARD_TICKS = 3'd2;
    localparam logic [2:0]         REG_SPIN_TICKS    = 3'd3;
    localparam logic [2:0]         REG_SHORT_TURN    = 3'd4;
    localparam logic [2:0]         REG_LONG_TURN     = 3'd5;
    localparam logic [2:0]         REG_DRIVE_SPEED   = 3'd6;
    localparam logic [2:0]         REG_TURN_RATE     = 3'd7;

    // skew codes, the unused code means no skew
    localparam logic [1:0] SKEW_NONE   = 2'b00;
    localparam logic [1:0] SKEW_RIGHT  = 2'b01;
    localparam logic [1:0] SKEW_UNUSED = 2'b10;
    localparam logic [1:0] SKEW_LEFT   = 2'b11;

    // reported phase codes
    localparam logic [PHASE_W-1:0] PH_CODE_SPIN  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_CODE_START = 3'd1;
    localparam logic [PHASE_W-1:0] PH_CODE_FWD   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_CODE_TA    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_CODE_TB    = 3'd4;
    localparam logic [PHASE_W-1:0] PH_CODE_TC    = 3'd5;

    // pattern phase, one-hot
    typedef enum logic [5:0] {
        PH_SPIN  = 6'b000001,
        PH_START = 6'b000010,
        PH_FWD   = 6'b000100,
        PH_TA    = 6'b001000,
        PH_TB    = 6'b010000,
        PH_TC    = 6'b100000
    } t_phase;

endpackage

// ----- sv/timed_search_pattern_sequencer_top.sv -----
// timed search pattern sequencer: per-tick drive command generator
// depends on tsps_pkg for constants, register map and the phase type
//
// an accepted input item is held in the input register, then moves to the result
// register when that register is empty or being drained;
// throughput: one item per cycle while the receiver keeps draining, set by the
// single-pass update of phase, elapsed and cycle counters between them
// reset (synchronous, active low): registers to defaults, phase spin, counters 0
module timed_search_pattern_sequencer_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tsps_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // tick input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_marker_present,
    // drive command channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [tsps_pkg::SPEED_W-1:0]    o_linear_speed,
    output logic signed [tsps_pkg::RATE_W-1:0] o_angular_rate,
    output logic [tsps_pkg::PHASE_W-1:0]    o_phase_now
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic                            r_spin_first;
    logic [1:0]                      r_skew;
    logic [15:0]                     r_forward_ticks;
    logic [15:0]                     r_spin_ticks;
    logic [15:0]                     r_short_turn;
    logic [15:0]                     r_long_turn;
    logic [tsps_pkg::SPEED_W-1:0]    r_drive_speed;
    logic [tsps_pkg::SPEED_W-1:0]    r_turn_rate;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[tsps_pkg::ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spin_first    <= 1'b0;
            r_skew          <= tsps_pkg::SKEW_NONE;
            r_forward_ticks <= tsps_pkg::FORWARD_TICKS_RST;
            r_spin_ticks    <= tsps_pkg::SPIN_TICKS_RST;
            r_short_turn    <= tsps_pkg::SHORT_TURN_RST;
            r_long_turn     <= tsps_pkg::LONG_TURN_RST;
            r_drive_speed   <= tsps_pkg::DRIVE_SPEED_RST;
            r_turn_rate     <= tsps_pkg::TURN_RATE_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                tsps_pkg::REG_SPIN_FIRST:    r_spin_first    <= pwdata[0];
                tsps_pkg::REG_SKEW:          r_skew          <= pwdata[1:0];
                tsps_pkg::REG_FORWARD_TICKS: r_forward_ticks <= pwdata[15:0];
                tsps_pkg::REG_SPIN_TICKS:    r_spin_ticks    <= pwdata[15:0];
                tsps_pkg::REG_SHORT_TURN:    r_short_turn    <= pwdata[15:0];
                tsps_pkg::REG_LONG_TURN:     r_long_turn     <= pwdata[15:0];
                tsps_pkg::REG_DRIVE_SPEED:   r_drive_speed   <= pwdata[tsps_pkg::SPEED_W-1:0];
                tsps_pkg::REG_TURN_RATE:     r_turn_rate     <= pwdata[tsps_pkg::SPEED_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // read mux, register values zero-extended
    always_comb begin
        case (cfg_idx)
            tsps_pkg::REG_SPIN_FIRST:    prdata = {31'd0, r_spin_first};
            tsps_pkg::REG_SKEW:          prdata = {30'd0, r_skew};
            tsps_pkg::REG_FORWARD_TICKS: prdata = {16'd0, r_forward_ticks};
            tsps_pkg::REG_SPIN_TICKS:    prdata = {16'd0, r_spin_ticks};
            tsps_pkg::REG_SHORT_TURN:    prdata = {16'd0, r_short_turn};
            tsps_pkg::REG_LONG_TURN:     prdata = {16'd0, r_long_turn};
            tsps_pkg::REG_DRIVE_SPEED:   prdata = {21'd0, r_drive_speed};
            tsps_pkg::REG_TURN_RATE:     prdata = {21'd0, r_turn_rate};
            default:                     prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline handshake: input register feeds result register
    // ------------------------------------------------------------------
    logic r_in_valid;
    logic r_in_marker;
    logic r_out_valid;
    logic advance;
    logic fire;

    // result register can load when empty or being drained
    assign advance    = ~r_out_valid | i_out_ready;
    assign o_in_ready = ~r_in_valid | advance;
    // an item moves from the input register to the result register
    assign fire       = r_in_valid & advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_marker <= i_marker_present;
        end
    end

    // ------------------------------------------------------------------
    // sequencer state
    // ------------------------------------------------------------------
    tsps_pkg::t_phase                    r_phase, n_phase;
    logic [tsps_pkg::ELAPSED_W-1:0]      r_elapsed, n_elapsed;
    logic [tsps_pkg::CYCLE_W-1:0]        r_cycle_count, n_cycle_count;

    logic [tsps_pkg::ELAPSED_W-1:0]      el_inc;
    logic [tsps_pkg::SPEED_W-1:0]        lin_clamped;
    logic [tsps_pkg::SPEED_W-1:0]        rate_clamped;
    logic signed [tsps_pkg::RATE_W-1:0]  ang_pos;
    logic signed [tsps_pkg::RATE_W-1:0]  ang_neg;
    logic                                skew_right;
    logic                                skewed;
    logic [tsps_pkg::PROD_W-1:0]         tc_extra;
    logic [tsps_pkg::SUM_W-1:0]          tc_sum;
    logic [tsps_pkg::ELAPSED_W-1:0]      tc_len;
    tsps_pkg::t_phase                    eff_phase;

    logic [tsps_pkg::SPEED_W-1:0]        n_lin;
    logic signed [tsps_pkg::RATE_W-1:0]  n_ang;
    logic [tsps_pkg::PHASE_W-1:0]        n_code;

    // saturating tick count
    assign el_inc = (r_elapsed != tsps_pkg::ELAPSED_MAX) ?
                    r_elapsed + 1'b1 : r_elapsed;

    // speed limits
    assign lin_clamped  = (r_drive_speed > tsps_pkg::SPEED_MAX) ?
                          tsps_pkg::SPEED_MAX : r_drive_speed;
    assign rate_clamped = (r_turn_rate > tsps_pkg::RATE_MAX) ?
                          tsps_pkg::RATE_MAX : r_turn_rate;
    assign ang_pos      = signed'({1'b0, rate_clamped});
    assign ang_neg      = -ang_pos;

    // skew decode, the unused code means no skew
    assign skew_right = (r_skew == tsps_pkg::SKEW_RIGHT);
    assign skewed     = (r_skew == tsps_pkg::SKEW_RIGHT) || (r_skew == tsps_pkg::SKEW_LEFT);

    // when skewed, turn c stretches one second per completed forward leg, saturating
    assign tc_extra = tsps_pkg::PROD_W'(r_cycle_count) *
                      tsps_pkg::PROD_W'(tsps_pkg::TICKS_PER_SECOND);
    assign tc_sum   = tsps_pkg::SUM_W'(r_short_turn) +
                      (skewed ? tsps_pkg::SUM_W'(tc_extra) : '0);
    assign tc_len   = (tc_sum > tsps_pkg::SUM_W'(tsps_pkg::ELAPSED_MAX)) ?
                      tsps_pkg::ELAPSED_MAX : tc_sum[tsps_pkg::ELAPSED_W-1:0];

    // spin phase with spin disabled behaves as the start phase
    assign eff_phase = ((r_phase == tsps_pkg::PH_SPIN) && !r_spin_first) ?
                       tsps_pkg::PH_START : r_phase;

    always_comb begin
        n_phase       = r_phase;
        n_elapsed     = el_inc;
        n_cycle_count = r_cycle_count;
        n_lin         = '0;
        n_ang         = '0;
        case (eff_phase)
            tsps_pkg::PH_SPIN:  n_code = tsps_pkg::PH_CODE_SPIN;
            tsps_pkg::PH_START: n_code = tsps_pkg::PH_CODE_START;
            tsps_pkg::PH_FWD:   n_code = tsps_pkg::PH_CODE_FWD;
            tsps_pkg::PH_TA:    n_code = tsps_pkg::PH_CODE_TA;
            tsps_pkg::PH_TB:    n_code = tsps_pkg::PH_CODE_TB;
            tsps_pkg::PH_TC:    n_code = tsps_pkg::PH_CODE_TC;
            default:            n_code = tsps_pkg::PH_CODE_START;
        endcase

        // marker present: stop, only the timer runs
        if (!r_in_marker) begin
            case (eff_phase)
                tsps_pkg::PH_SPIN: begin
                    n_ang = ang_pos;
                    if (el_inc >= r_spin_ticks) begin
                        n_phase   = tsps_pkg::PH_START;
                        n_elapsed = '0;
                    end
                end
                tsps_pkg::PH_FWD: begin
                    n_lin = lin_clamped;
                    if (el_inc >= r_forward_ticks) begin
                        n_phase   = tsps_pkg::PH_TA;
                        n_elapsed = '0;
                        if (r_cycle_count != tsps_pkg::CYCLE_MAX) begin
                            n_cycle_count = r_cycle_count + 1'b1;
                        end
                    end
                end
                tsps_pkg::PH_TA: begin
                    n_ang = skew_right ? ang_neg : ang_pos;
                    if (el_inc >= r_short_turn) begin
                        n_phase   = tsps_pkg::PH_TB;
                        n_elapsed = '0;
                    end
                end
                tsps_pkg::PH_TB: begin
                    n_ang = skew_right ? ang_pos : ang_neg;
                    if (el_inc >= r_long_turn) begin
                        n_phase   = tsps_pkg::PH_TC;
                        n_elapsed = '0;
                    end
                end
                tsps_pkg::PH_TC: begin
                    n_ang = skew_right ? ang_neg : ang_pos;
                    if (el_inc >= tc_len) begin
                        n_phase   = tsps_pkg::PH_FWD;
                        n_elapsed = '0;
                    end
                end
                default: begin
                    // start: one tick of forward drive
                    n_lin     = lin_clamped;
                    n_phase   = tsps_pkg::PH_FWD;
                    n_elapsed = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= tsps_pkg::PH_SPIN;
            r_elapsed     <= '0;
            r_cycle_count <= '0;
        end else if (fire) begin
            r_phase       <= n_phase;
            r_elapsed     <= n_elapsed;
            r_cycle_count <= n_cycle_count;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic [tsps_pkg::SPEED_W-1:0]        r_lin;
    logic signed [tsps_pkg::RATE_W-1:0]  r_ang;
    logic [tsps_pkg::PHASE_W-1:0]        r_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_lin  <= n_lin;
            r_ang  <= n_ang;
            r_code <= n_code;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_linear_speed = r_lin;
    assign o_angular_rate = r_ang;
    assign o_phase_now    = r_code;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // turning phases never drive forward
    a_turn_no_lin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_phase_now == tsps_pkg::PH_CODE_TA ||
                         o_phase_now == tsps_pkg::PH_CODE_TB ||
                         o_phase_now == tsps_pkg::PH_CODE_TC))
        |-> (o_linear_speed == '0))
        else $error("linear speed nonzero during a turn");

    // a phase change always restarts the timer
    a_phase_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != $past(r_phase)) |-> (r_elapsed == '0))
        else $error("elapsed not cleared on phase change");

    // the cycle counter only counts up
    a_cycle_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_cycle_count >= $past(r_cycle_count)))
        else $error("cycle count decreased");

    // state moves only when an item passes to the result register
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(fire)) |-> ($stable(r_phase) && $stable(r_elapsed)))
        else $error("state changed without an item");

endmodule

// ----- tb/tsps_check_pkg.sv -----
// scoreboard for the timed search pattern sequencer: predicts the drive command
// of every accepted tick and checks the commands of the block in order
// depends on tsps_pkg for widths, limits, register indexes and phase codes
package tsps_check_pkg;

    typedef struct {
        logic [tsps_pkg::SPEED_W-1:0]       linear_speed;
        logic signed [tsps_pkg::RATE_W-1:0] angular_rate;
        logic [tsps_pkg::PHASE_W-1:0]       phase_now;
    } t_drive_cmd;

    class t_drive_cmd_board;
        // registers as the block should hold them
        logic                           spin_first;
        logic [1:0]                     skew;
        logic [15:0]                    forward_ticks;
        logic [15:0]                    spin_ticks;
        logic [15:0]                    short_turn_ticks;
        logic [15:0]                    long_turn_ticks;
        logic [tsps_pkg::SPEED_W-1:0]   drive_speed;
        logic [10:0]                    turn_rate;
        // pattern state
        logic [tsps_pkg::PHASE_W-1:0]   phase;
        logic [tsps_pkg::ELAPSED_W-1:0] elapsed;
        logic [tsps_pkg::CYCLE_W-1:0]   cycle_count;

        t_drive_cmd  cmd_due[$];
        int unsigned mismatches;
        int unsigned strays;

        function new();
            spin_first       = 1'b0;
            skew             = tsps_pkg::SKEW_NONE;
            forward_ticks    = tsps_pkg::FORWARD_TICKS_RST;
            spin_ticks       = tsps_pkg::SPIN_TICKS_RST;
            short_turn_ticks = tsps_pkg::SHORT_TURN_RST;
            long_turn_ticks  = tsps_pkg::LONG_TURN_RST;
            drive_speed      = tsps_pkg::DRIVE_SPEED_RST;
            turn_rate        = tsps_pkg::TURN_RATE_RST;
            phase            = tsps_pkg::PH_CODE_SPIN;
            elapsed          = '0;
            cycle_count      = '0;
            mismatches       = 0;
            strays           = 0;
        endfunction

        function void set_reg(input logic [2:0] idx, input logic [31:0] value);
            case (idx)
                tsps_pkg::REG_SPIN_FIRST:    spin_first       = value[0];
                tsps_pkg::REG_SKEW:          skew             = value[1:0];
                tsps_pkg::REG_FORWARD_TICKS: forward_ticks    = value[15:0];
                tsps_pkg::REG_SPIN_TICKS:    spin_ticks       = value[15:0];
                tsps_pkg::REG_SHORT_TURN:    short_turn_ticks = value[15:0];
                tsps_pkg::REG_LONG_TURN:     long_turn_ticks  = value[15:0];
                tsps_pkg::REG_DRIVE_SPEED:   drive_speed      = value[tsps_pkg::SPEED_W-1:0];
                tsps_pkg::REG_TURN_RATE:     turn_rate        = value[10:0];
                default: ;
            endcase
        endfunction

        function void enter(input logic [tsps_pkg::PHASE_W-1:0] next);
            phase   = next;
            elapsed = '0;
        endfunction

        // one tick: command of the current phase, then the phase timer
        function void note_tick(input logic mark);
            logic [tsps_pkg::SPEED_W-1:0]       lin;
            logic [10:0]                        rate;
            logic signed [tsps_pkg::RATE_W-1:0] turn;
            logic                               right;
            logic                               skewed;
            logic [tsps_pkg::PHASE_W-1:0]       ph;
            int unsigned                        tc_len;
            t_drive_cmd                         cmd;
            lin    = (drive_speed > tsps_pkg::SPEED_MAX) ? tsps_pkg::SPEED_MAX : drive_speed;
            rate   = (turn_rate > tsps_pkg::RATE_MAX) ? tsps_pkg::RATE_MAX : turn_rate;
            turn   = {1'b0, rate};
            right  = (skew == tsps_pkg::SKEW_RIGHT);
            skewed = right || (skew == tsps_pkg::SKEW_LEFT);
            ph     = (phase == tsps_pkg::PH_CODE_SPIN && !spin_first) ?
                     tsps_pkg::PH_CODE_START : phase;
            if (elapsed != tsps_pkg::ELAPSED_MAX)
                elapsed++;
            cmd.linear_speed = '0;
            cmd.angular_rate = '0;
            cmd.phase_now    = ph;
            if (!mark) begin
                case (ph)
                    tsps_pkg::PH_CODE_SPIN: begin
                        cmd.angular_rate = turn;
                        if (elapsed >= spin_ticks)
                            enter(tsps_pkg::PH_CODE_START);
                    end
                    tsps_pkg::PH_CODE_START: begin
                        cmd.linear_speed = lin;
                        enter(tsps_pkg::PH_CODE_FWD);
                    end
                    tsps_pkg::PH_CODE_FWD: begin
                        cmd.linear_speed = lin;
                        if (elapsed >= forward_ticks) begin
                            if (cycle_count != tsps_pkg::CYCLE_MAX)
                                cycle_count++;
                            enter(tsps_pkg::PH_CODE_TA);
                        end
                    end
                    tsps_pkg::PH_CODE_TA: begin
                        cmd.angular_rate = right ? -turn : turn;
                        if (elapsed >= short_turn_ticks)
                            enter(tsps_pkg::PH_CODE_TB);
                    end
                    tsps_pkg::PH_CODE_TB: begin
                        cmd.angular_rate = right ? turn : -turn;
                        if (elapsed >= long_turn_ticks)
                            enter(tsps_pkg::PH_CODE_TC);
                    end
                    default: begin
                        // turn c grows one second per completed leg when skewed
                        cmd.angular_rate = right ? -turn : turn;
                        tc_len = 32'(short_turn_ticks);
                        if (skewed)
                            tc_len += 32'(cycle_count) * tsps_pkg::TICKS_PER_SECOND;
                        if (tc_len > 32'(tsps_pkg::ELAPSED_MAX))
                            tc_len = 32'(tsps_pkg::ELAPSED_MAX);
                        if (32'(elapsed) >= tc_len)
                            enter(tsps_pkg::PH_CODE_FWD);
                    end
                endcase
            end
            cmd_due.insert(cmd_due.size(), cmd);
        endfunction

        function void check_cmd(input logic [tsps_pkg::SPEED_W-1:0] lin,
                                input logic signed [tsps_pkg::RATE_W-1:0] ang,
                                input logic [tsps_pkg::PHASE_W-1:0] ph);
            t_drive_cmd due;
            if (cmd_due.size() == 0) begin
                strays++;
                if (mismatches + strays <= 10)
                    $display("stray drive command: speed %0d rate %0d phase %0d",
                             lin, ang, ph);
                return;
            end
            due = cmd_due.pop_front();
            if (lin !== due.linear_speed || ang !== due.angular_rate ||
                ph !== due.phase_now) begin
                mismatches++;
                if (mismatches + strays <= 10)
                    $display("drive command mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                             due.linear_speed, due.angular_rate, due.phase_now,
                             lin, ang, ph);
            end
        endfunction

        function int unsigned faults();
            return mismatches + strays + cmd_due.size();
        endfunction
    endclass

endpackage

// ----- tb/tb_top.sv -----
// top of the timed search pattern sequencer testbench: clock, reset, tick sender,
// command receiver, register writes, watchdog and verdict
// depends on tsps_pkg, tsps_check_pkg and timed_search_pattern_sequencer_top
module tb_top;

    // quiet cycles allowed: the longest receiver hold is HOLD_CYCLES and random
    // gaps on either side are short geometric runs, so this is many times over
    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 48;
    localparam int RANDOM_ROUNDS = 7;
    localparam int ROUND_TICKS   = 80;

    logic                                 i_clk            = 1'b0;
    logic                                 i_rst_n          = 1'b0;
    logic                                 psel             = 1'b0;
    logic                                 penable          = 1'b0;
    logic                                 pwrite           = 1'b0;
    logic [tsps_pkg::ADDR_W-1:0]          paddr            = '0;
    logic [31:0]                          pwdata           = '0;
    logic [31:0]                          prdata;
    logic                                 pready;
    logic                                 i_in_valid       = 1'b0;
    logic                                 o_in_ready;
    logic                                 i_marker_present = 1'b0;
    logic                                 o_out_valid;
    logic                                 i_out_ready      = 1'b0;
    logic [tsps_pkg::SPEED_W-1:0]         o_linear_speed;
    logic signed [tsps_pkg::RATE_W-1:0]   o_angular_rate;
    logic [tsps_pkg::PHASE_W-1:0]         o_phase_now;

    tsps_check_pkg::t_drive_cmd_board board;
    int unsigned    tx_idle_pct  = 0;
    int unsigned    rx_idle_pct  = 0;
    bit             hold_request = 1'b0;
    int unsigned    ticks_sent   = 0;
    int unsigned    cmds_seen    = 0;
    int unsigned    quiet        = 0;

    always #5 i_clk = ~i_clk;

    timed_search_pattern_sequencer_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_marker_present (i_marker_present),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_linear_speed   (o_linear_speed),
        .o_angular_rate   (o_angular_rate),
        .o_phase_now      (o_phase_now)
    );

    // command receiver: random ready, or one long hold counted here
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // both handshakes sampled with pre-edge values, tick noted before command check
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                board.note_tick(i_marker_present);
            if (o_out_valid && i_out_ready) begin
                board.check_cmd(o_linear_speed, o_angular_rate, o_phase_now);
                cmds_seen++;
            end
        end
    end

    // watchdog on cycles with no item moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet <= 0;
        end else if (quiet + 1 >= QUIET_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // offer one tick after a random gap, return at the edge that takes it
    task automatic send_tick(input logic mark);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_marker_present <= mark;
        do @(posedge i_clk); while (!o_in_ready);
        ticks_sent++;
    endtask

    // marks go out lsb first
    task automatic send_marks(input logic [15:0] marks, input int count);
        for (int k = 0; k < count; k++)
            send_tick(marks[k]);
    endtask

    // every tick gives one command, so equal counts mean the block is idle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (cmds_seen != ticks_sent)
            @(posedge i_clk);
    endtask

    // setup then access phase; junk above the register width must be dropped
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] keep;
        keep = (idx == tsps_pkg::REG_SPIN_FIRST) ? 32'h1 :
               (idx == tsps_pkg::REG_SKEW) ? 32'h3 :
               (idx == tsps_pkg::REG_DRIVE_SPEED || idx == tsps_pkg::REG_TURN_RATE) ?
               32'h7FF : 32'hFFFF;
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= (value & keep) | ($urandom & ~keep);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_reg(idx, value & keep);
        // the bus returns to idle before any back-to-back write
        @(posedge i_clk);
    endtask

    // phase lengths: mostly short so the pattern keeps turning over
    function automatic logic [31:0] pick_ticks();
        case ($urandom_range(0, 15))
            0:       return 0;
            1:       return 32'hFFFF;
            2:       return $urandom_range(0, 32'hFFFF);
            3:       return $urandom_range(11, 300);
            default: return $urandom_range(1, 10);
        endcase
    endfunction

    // speed or rate around its clamp bound
    function automatic logic [31:0] pick_level(input logic [10:0] cap);
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return cap;
            2:       return cap + 1;
            3:       return 32'h7FF;
            default: return $urandom_range(0, 32'h7FF);
        endcase
    endfunction

    initial begin
        int unsigned round;
        int unsigned mark_pct;
        board = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // markers while the spin is off: reported as start, phase 0 kept
        send_marks(16'h0003, 2);
        // spin turned on late still runs, timed from reset; clamped speeds,
        // zero lengths, right skew
        write_reg(tsps_pkg::REG_SPIN_FIRST, 1);
        write_reg(tsps_pkg::REG_SPIN_TICKS, 5);
        write_reg(tsps_pkg::REG_DRIVE_SPEED, 32'h7FF);
        write_reg(tsps_pkg::REG_TURN_RATE, 32'h7FF);
        write_reg(tsps_pkg::REG_FORWARD_TICKS, 0);
        write_reg(tsps_pkg::REG_SHORT_TURN, 0);
        write_reg(tsps_pkg::REG_LONG_TURN, 2);
        write_reg(tsps_pkg::REG_SKEW, tsps_pkg::SKEW_RIGHT);
        // spin, marker in spin, start, forward, turns a and b, marker in turn c
        send_marks(16'h0102, 10);
        // unused skew code counts as no skew: turn c ends at once, mid-phase
        write_reg(tsps_pkg::REG_SKEW, tsps_pkg::SKEW_UNUSED);
        send_marks(16'h0000, 3);
        // left skew with zero speed and rate
        write_reg(tsps_pkg::REG_SKEW, tsps_pkg::SKEW_LEFT);
        write_reg(tsps_pkg::REG_DRIVE_SPEED, 0);
        write_reg(tsps_pkg::REG_TURN_RATE, 0);
        send_marks(16'h0004, 4);

        // random rounds: sender-light then receiver-light idling, then none
        for (round = 0; round < RANDOM_ROUNDS; round++) begin
            tx_idle_pct = (round < 3) ? 38 : (round < 5) ? 67 : 0;
            rx_idle_pct = (round < 3) ? 67 : (round < 5) ? 38 : 0;
            case ($urandom_range(0, 3))
                0:       mark_pct = 0;
                1:       mark_pct = 10;
                2:       mark_pct = 30;
                default: mark_pct = 60;
            endcase
            write_reg(tsps_pkg::REG_SPIN_FIRST, $urandom_range(0, 1));
            write_reg(tsps_pkg::REG_SKEW, $urandom_range(0, 3));
            write_reg(tsps_pkg::REG_FORWARD_TICKS, pick_ticks());
            write_reg(tsps_pkg::REG_SPIN_TICKS, pick_ticks());
            write_reg(tsps_pkg::REG_SHORT_TURN, pick_ticks());
            write_reg(tsps_pkg::REG_LONG_TURN, pick_ticks());
            write_reg(tsps_pkg::REG_DRIVE_SPEED, pick_level(tsps_pkg::SPEED_MAX));
            write_reg(tsps_pkg::REG_TURN_RATE, pick_level(tsps_pkg::RATE_MAX));
            repeat (ROUND_TICKS)
                send_tick($urandom_range(0, 99) < mark_pct);
        end

        // back-pressure: receiver holds while ticks keep coming and fill the block
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_request = 1'b1;
        repeat (60)
            send_tick($urandom_range(0, 3) == 0);
        // sender waits for every command before going on
        wait_drained();
        repeat (20)
            send_tick($urandom_range(0, 3) == 0);

        // four-tick pattern for a few legs, then stop at the start of turn c
        write_reg(tsps_pkg::REG_SKEW, tsps_pkg::SKEW_NONE);
        write_reg(tsps_pkg::REG_FORWARD_TICKS, 0);
        write_reg(tsps_pkg::REG_SHORT_TURN, 0);
        write_reg(tsps_pkg::REG_LONG_TURN, 0);
        repeat (20)
            send_tick(1'b0);
        wait_drained();
        while (board.phase != tsps_pkg::PH_CODE_TC) begin
            send_tick(1'b0);
            wait_drained();
        end
        // turn c length saturates; a wrapped length would end within a few ticks
        write_reg(tsps_pkg::REG_SKEW, tsps_pkg::SKEW_RIGHT);
        write_reg(tsps_pkg::REG_SHORT_TURN,
                  32'd65541 - 32'(board.cycle_count) * tsps_pkg::TICKS_PER_SECOND);
        repeat (30)
            send_tick($urandom_range(0, 3) == 0);

        // drain, then idle on to catch any stray command
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (board.faults() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ----- files.f -----
sv/tsps_pkg.sv
sv/timed_search_pattern_sequencer_top.sv
tb/tsps_check_pkg.sv
tb/tb_top.sv
